>>> rtl/core/first_fit_extent_allocator_top_assert.svh
// Assertion macros for the checker file of the extent allocator.
// Included by bare file name; no other dependencies.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_TOP_ASSERT_SVH

// Property checked at every rising edge, suspended while reset is high.
`define FFEA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define FFEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ffea_pkg.sv
// Shared constants for the first-fit extent allocator.
// No dependencies; imported by the interfaces, the top level and the checker.
package ffea_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] POOL_BASE_RST = 32'h0000_0000;
  localparam logic [DATA_W-1:0] POOL_SIZE_RST = 32'h0010_0000;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

endpackage

>>> rtl/core/ffea_req_if.sv
// Request channel of the extent allocator: valid/ready plus one request.
// Depends on ffea_pkg for the field width.
interface ffea_req_if import ffea_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [DATA_W-1:0] request_length;
  logic [DATA_W-1:0] free_address;

  modport source (output valid, output func, output request_length, output free_address,
                  input ready);
  modport sink (input valid, input func, input request_length, input free_address,
                output ready);
endinterface

>>> rtl/core/ffea_rsp_if.sv
// Response channel of the extent allocator: valid/ready plus one result.
// Depends on ffea_pkg for the field width.
interface ffea_rsp_if import ffea_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] granted_address;
  logic [1:0]        status;
  logic [DATA_W-1:0] lowest_free_base;
  logic              lowest_free_valid;

  modport source (output valid, output granted_address, output status,
                  output lowest_free_base, output lowest_free_valid, input ready);
  modport sink (input valid, input granted_address, input status,
                input lowest_free_base, input lowest_free_valid, output ready);
endinterface

>>> rtl/core/ffea_cfg_if.sv
// Register write channel of the extent allocator: valid/ready, index and data.
// Depends on ffea_pkg for the index and data widths.
interface ffea_cfg_if import ffea_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/ffea_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module ffea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/first_fit_extent_allocator_top.sv
// First-fit extent allocator: top level with sequencer and extent table.
// Depends on ffea_pkg, the three channel interfaces and ffea_ram.
//
// Usage: a request transaction on req carries func (allocate or free), a
// length and, for a free, the start address. Each request yields exactly one
// transaction on rsp: the granted base, a status code and the lowest free base
// after the request. Writes on cfg set pool_base or pool_size and rebuild the
// table as one extent covering the pool; cfg is taken only while idle.
// Requests are handled one at a time. The extent table sits in a RAM with one
// write and one registered read port, so each table entry is first read in a
// read state and then checked in a check state. An allocate searches for the
// first extent that fits, a free searches for its slot, entries are moved to
// open or close a hole when needed, and then empty extents are skipped to find
// the lowest non-empty one before the result is registered. After that the
// block returns to idle and can take the next request.
// Reset (synchronous, active high) restores the default pool and writes the
// first table entry in S_INIT before req is ready. The result sits in an
// output register; while the receiver stalls, the next request is still
// worked out and then waits until that register frees up.
module first_fit_extent_allocator_top import ffea_pkg::*; #(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_WIDTH  = 32
) (
  input logic       clk,
  input logic       rst,
  ffea_req_if.sink   req,
  ffea_rsp_if.source rsp,
  ffea_cfg_if.sink   cfg
);

  localparam int AW = ADDR_WIDTH;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = $clog2(MAX_EXTENTS);

  typedef struct packed {
    logic [AW-1:0] s;
    logic [AW-1:0] n;
  } ext_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_F_DEC, S_F_MRG,
    S_SH_RD, S_SH_WR, S_LF_RD, S_LF_CHK, S_FIN
  } state_t;

  state_t state;

  logic [DATA_W-1:0] pool_base;
  logic [DATA_W-1:0] pool_size;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     sh_j;
  logic              sh_up;
  logic              hit_end;
  logic [AW-1:0]     len_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     prev_s;
  logic [AW-1:0]     prev_n;
  logic [AW-1:0]     prev_end;
  logic [AW-1:0]     msz;
  logic [AW-1:0]     granted_q;
  logic [1:0]        status_q;
  logic [AW-1:0]     lf_base;
  logic              lf_valid;

  logic              rsp_valid_q;
  logic [DATA_W-1:0] rsp_granted;
  logic [1:0]        rsp_status;
  logic [DATA_W-1:0] rsp_lf_base;
  logic              rsp_lf_valid;

  // RAM port controls.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  ext_t          ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  ext_t          cur;

  // Datapath.
  logic [AW-1:0] req_len;
  logic [AW:0]   a_diff;
  logic          a_fit;
  logic [AW-1:0] cur_end;
  logic [AW-1:0] new_prev_n;
  logic [AW-1:0] new_prev_end;
  logic [AW-1:0] tail;
  logic          f_prev_hit;
  logic          f_next_join;
  logic          f_tail;
  logic [CW-1:0] sh_nx;
  logic [CW-1:0] idx_m1;

  ffea_ram #(
    .WIDTH (2 * AW),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (cur)
  );

  assign req_len      = AW'(req.request_length);
  assign a_diff       = {1'b0, cur.n} - {1'b0, len_q};
  assign a_fit        = !a_diff[AW];
  assign cur_end      = cur.s + cur.n;
  assign new_prev_n   = prev_n + len_q;
  assign new_prev_end = prev_end + len_q;
  assign tail         = addr_q + len_q;
  assign f_prev_hit   = (idx != '0) && (prev_end == addr_q);
  assign f_next_join  = !hit_end && (new_prev_end == cur.s);
  assign f_tail       = !hit_end && (tail == cur.s);
  assign sh_nx        = sh_j + CW'(1);
  assign idx_m1       = idx - CW'(1);

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;

  assign rsp.valid             = rsp_valid_q;
  assign rsp.granted_address   = rsp_granted;
  assign rsp.status            = rsp_status;
  assign rsp.lowest_free_base  = rsp_lf_base;
  assign rsp.lowest_free_valid = rsp_lf_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '{s: '0, n: '0};
    ram_re    = 1'b0;
    ram_raddr = idx[IW-1:0];
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{s: AW'(pool_base), n: AW'(pool_size)};
      end
      S_A_RD, S_F_RD, S_LF_RD: begin
        ram_re = (idx != count);
      end
      S_A_CHK: begin
        if (a_fit && (a_diff[AW-1:0] != '0)) begin
          ram_we    = 1'b1;
          ram_waddr = idx[IW-1:0];
          ram_wdata = '{s: cur.s + len_q, n: a_diff[AW-1:0]};
        end
      end
      S_F_DEC: begin
        if (f_prev_hit) begin
          if (!f_next_join) begin
            ram_we    = 1'b1;
            ram_waddr = idx_m1[IW-1:0];
            ram_wdata = '{s: prev_s, n: new_prev_n};
          end
        end else if (f_tail) begin
          ram_we    = 1'b1;
          ram_waddr = idx[IW-1:0];
          ram_wdata = '{s: addr_q, n: cur.n + len_q};
        end
      end
      S_F_MRG: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[IW-1:0];
        ram_wdata = '{s: prev_s, n: msz + cur.n};
      end
      S_SH_RD: begin
        if (sh_up) begin
          if (sh_j == idx) begin
            // The hole is open: place the freed region.
            ram_we    = 1'b1;
            ram_waddr = sh_j[IW-1:0];
            ram_wdata = '{s: addr_q, n: len_q};
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_m1[IW-1:0] + (sh_j[IW-1:0] - idx[IW-1:0]);
          end
        end else if (sh_nx < count) begin
          ram_re    = 1'b1;
          ram_raddr = sh_nx[IW-1:0];
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_j[IW-1:0];
        ram_wdata = cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      pool_base   <= POOL_BASE_RST;
      pool_size   <= POOL_SIZE_RST;
      count       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // In S_FIN the output register is reloaded when it is empty or the receiver is ready.
      if (rsp.ready && (state != S_FIN)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state)
        S_INIT: begin
          count <= (AW'(pool_size) != '0) ? CW'(1) : '0;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg.valid) begin
            if (cfg.index == REG_POOL_BASE) begin
              pool_base <= cfg.data;
              state     <= S_INIT;
            end else if (cfg.index == REG_POOL_SIZE) begin
              pool_size <= cfg.data;
              state     <= S_INIT;
            end
          end else if (req.valid) begin
            len_q     <= req_len;
            addr_q    <= AW'(req.free_address);
            granted_q <= '0;
            status_q  <= ((req_len == '0) && (req.func == FUNC_ALLOC)) ? ST_NO_SPACE : ST_OK;
            idx       <= '0;
            hit_end   <= 1'b0;
            if (req_len == '0) begin
              state <= S_LF_RD;
            end else if (req.func == FUNC_ALLOC) begin
              state <= S_A_RD;
            end else begin
              state <= S_F_RD;
            end
          end
        end
        S_A_RD: begin
          if (idx == count) begin
            status_q <= ST_NO_SPACE;
            idx      <= '0;
            state    <= S_LF_RD;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (a_fit) begin
            granted_q <= cur.s;
            if (a_diff[AW-1:0] == '0) begin
              // Extent used up: close the gap.
              sh_j  <= idx;
              sh_up <= 1'b0;
              state <= S_SH_RD;
            end else begin
              idx   <= '0;
              state <= S_LF_RD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_A_RD;
          end
        end
        S_F_RD: begin
          if (idx == count) begin
            hit_end <= 1'b1;
            state   <= S_F_DEC;
          end else begin
            state <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if (cur_end <= addr_q) begin
            prev_s   <= cur.s;
            prev_n   <= cur.n;
            prev_end <= cur_end;
            idx      <= idx + CW'(1);
            state    <= S_F_RD;
          end else begin
            state <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          if (f_prev_hit) begin
            if (f_next_join) begin
              msz   <= new_prev_n;
              state <= S_F_MRG;
            end else begin
              idx   <= '0;
              state <= S_LF_RD;
            end
          end else if (f_tail) begin
            idx   <= '0;
            state <= S_LF_RD;
          end else if (count == CW'(MAX_EXTENTS)) begin
            status_q <= ST_TABLE_FULL;
            idx      <= '0;
            state    <= S_LF_RD;
          end else begin
            // Open a hole at idx by moving the tail of the table up.
            sh_j  <= count;
            sh_up <= 1'b1;
            state <= S_SH_RD;
          end
        end
        S_F_MRG: begin
          sh_j  <= idx;
          sh_up <= 1'b0;
          state <= S_SH_RD;
        end
        S_SH_RD: begin
          if (sh_up) begin
            if (sh_j == idx) begin
              count <= count + CW'(1);
              idx   <= '0;
              state <= S_LF_RD;
            end else begin
              state <= S_SH_WR;
            end
          end else if (sh_nx < count) begin
            state <= S_SH_WR;
          end else begin
            count <= count - CW'(1);
            idx   <= '0;
            state <= S_LF_RD;
          end
        end
        S_SH_WR: begin
          sh_j  <= sh_up ? sh_j - CW'(1) : sh_nx;
          state <= S_SH_RD;
        end
        S_LF_RD: begin
          if (idx == count) begin
            lf_base  <= '0;
            lf_valid <= 1'b0;
            state    <= S_FIN;
          end else begin
            state <= S_LF_CHK;
          end
        end
        S_LF_CHK: begin
          if (cur.n != '0) begin
            lf_base  <= cur.s;
            lf_valid <= 1'b1;
            state    <= S_FIN;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_LF_RD;
          end
        end
        S_FIN: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_granted  <= DATA_W'(granted_q);
            rsp_status   <= status_q;
            rsp_lf_base  <= DATA_W'(lf_base);
            rsp_lf_valid <= lf_valid;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/ffea_checker.sv
// Port-level checker for the extent allocator and its bind to the top level.
// Depends on ffea_pkg and first_fit_extent_allocator_top_assert.svh.
`include "first_fit_extent_allocator_top_assert.svh"

module ffea_checker import ffea_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] rsp_granted_address,
  input logic [1:0]        rsp_status,
  input logic [DATA_W-1:0] rsp_lowest_free_base,
  input logic              rsp_lowest_free_valid
);

  // The table entry is rebuilt right after reset, so requests wait for it.
  `FFEA_ASSERT_ALWAYS(a_busy_after_reset, clk, rst |=> !req_ready, "req ready right after reset")

  // A request keeps the block busy for at least the following cycle.
  `FFEA_ASSERT(a_busy_after_req, clk, rst, req_valid && req_ready |=> !req_ready, "req ready twice in a row")

  `FFEA_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_address) && $stable(rsp_status), "stalled response changed")

  // Only a successful allocate carries a nonzero granted base.
  `FFEA_ASSERT(a_grant_on_error, clk, rst, rsp_valid && rsp_status != ST_OK |-> rsp_granted_address == '0, "granted base set on failure")

  `FFEA_ASSERT(a_lowest_empty, clk, rst, rsp_valid && !rsp_lowest_free_valid |-> rsp_lowest_free_base == '0, "lowest base set with no free extent")

endmodule

bind first_fit_extent_allocator_top ffea_checker u_ffea_checker (
  .clk                   (clk),
  .rst                   (rst),
  .req_valid             (req.valid),
  .req_ready             (req.ready),
  .rsp_valid             (rsp.valid),
  .rsp_ready             (rsp.ready),
  .rsp_granted_address   (rsp.granted_address),
  .rsp_status            (rsp.status),
  .rsp_lowest_free_base  (rsp.lowest_free_base),
  .rsp_lowest_free_valid (rsp.lowest_free_valid)
);
